// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/rqdf_pkg.sv =====
// ----------------------------------------------------------------------------
// rqdf_pkg
// Shared widths and types for the recent query duplicate filter.
// ----------------------------------------------------------------------------
package rqdf_pkg;

   localparam int HISTORY_DEPTH = 16;
   localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   localparam int QUERY_ID_W = 16;
   localparam int IPV4_W     = 32;
   localparam int PORT_W     = 16;
   localparam int KEY_W      = QUERY_ID_W + IPV4_W + PORT_W;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [KEY_W-1:0]  key_type;

endpackage

// ===== rtl/rqdf_if.sv =====
// ----------------------------------------------------------------------------
// rqdf request / response channels
// Valid/ready channels carrying query requests and duplicate-check results.
// ----------------------------------------------------------------------------
interface rqdf_req_if;
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic [rqdf_pkg::QUERY_ID_W-1:0]   query_id;
   logic [rqdf_pkg::IPV4_W-1:0]       origin_ipv4;
   logic [rqdf_pkg::PORT_W-1:0]       origin_port;

   modport source (output valid, action, query_id, origin_ipv4, origin_port, input ready);
   modport sink   (input valid, action, query_id, origin_ipv4, origin_port, output ready);
endinterface

interface rqdf_rsp_if;
   logic valid;
   logic ready;
   logic seen;

   modport source (output valid, seen, input ready);
   modport sink   (input valid, seen, output ready);
endinterface

// ===== rtl/recent_query_duplicate_filter_top.sv =====
// ----------------------------------------------------------------------------
// recent_query_duplicate_filter_top
// Duplicate filter for flooded search queries over a FIFO history of keys.
//
// Each request carries a key (query id, origin IPv4, origin port) and an
// action. The key is compared with every valid history entry and the response
// says whether it was already there; with action record the key is then
// appended, overwriting the oldest entry once the history is full. Keys live
// in a synchronous memory with one write port and one registered read port
// that is scanned one entry per cycle, so a request passes through the scan,
// a drain state and a finish state, which waits while an earlier response
// is still held, before the next request can be taken; that scan sets the
// rate. The result sits in an output register, so a new request is accepted
// while an earlier response still waits. The per-entry valid flags clear
// together at reset; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module recent_query_duplicate_filter_top (
   input logic        clock,
   input logic        reset,
   rqdf_req_if.sink   req_bus,
   rqdf_rsp_if.source rsp_bus
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   rqdf_pkg::key_type hist_mem [rqdf_pkg::HISTORY_DEPTH];

   logic [1:0]                         state_ff, state_in;
   rqdf_pkg::slot_type                 scan_idx_ff, scan_idx_in;
   rqdf_pkg::slot_type                 cmp_idx_ff;
   logic                               cmp_vld_ff, cmp_vld_in;
   logic                               hit_ff, hit_in;
   rqdf_pkg::slot_type                 oldest_ff, oldest_in;
   logic [rqdf_pkg::HISTORY_DEPTH-1:0] valid_ff, valid_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               seen_ff;
   rqdf_pkg::key_type                  key_ff;
   rqdf_pkg::key_type                  rd_data_ff;
   logic                               record_ff;

   logic req_fire;
   logic hit_now;
   logic rsp_load;
   logic mem_we;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.seen  = seen_ff;

   assign hit_now  = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_data_ff == key_ff);
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);
   assign mem_we   = rsp_load && record_ff;

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = (state_ff == ST_SCAN);
      hit_in       = hit_ff | hit_now;
      oldest_in    = oldest_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
               hit_in      = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == rqdf_pkg::LAST_SLOT) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         // last read still in flight
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (record_ff) begin
                  valid_in[oldest_ff] = 1'b1;
                  oldest_in = (oldest_ff == rqdf_pkg::LAST_SLOT) ? '0 : oldest_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         oldest_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         hit_ff       <= hit_in;
         oldest_ff    <= oldest_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_ff    <= {req_bus.query_id, req_bus.origin_ipv4, req_bus.origin_port};
         record_ff <= req_bus.action;
      end
      if (rsp_load) begin
         seen_ff <= hit_ff;
      end
      cmp_idx_ff <= scan_idx_ff;
   end

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[oldest_ff] <= key_ff;
      end
      rd_data_ff <= hist_mem[scan_idx_ff];
   end

   `ASSERT_NEXT(a_slot_moves_on_finish, state_ff != ST_FINISH, $stable(oldest_ff))
   `ASSERT_IMPLIES(a_cmp_in_scan, cmp_vld_ff, state_ff == ST_SCAN || state_ff == ST_DRAIN)
   `ASSERT_NEXT(a_rsp_set_from_finish, !rsp_valid_ff && rsp_valid_in, $past(state_ff) == ST_FINISH)

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the recent query duplicate filter against a cycle-free model of its
// key history. Queries go in through a bursty driver and results are drained
// by a stalling receiver. Each result's seen flag is compared in order
// against the prediction made when the request was accepted.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic ACT_CHECK  = 1'b0;
   localparam logic ACT_RECORD = 1'b1;

   localparam int RANDOM_QUERIES = 1400;
   localparam int IDLE_LIMIT     = 3000;
   localparam int HOLD_AT        = 400;   // responses drained before the long hold
   localparam int HOLD_CYCLES    = 300;
   localparam int POOL_DEPTH     = 24;    // recent recorded keys reused for hits

   typedef struct packed {
      logic              action;
      rqdf_pkg::key_type key;
   } query_item_type;

   logic clock;
   logic reset;

   rqdf_req_if req_ch ();
   rqdf_rsp_if rsp_ch ();

   recent_query_duplicate_filter_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   // model of the key history
   rqdf_pkg::key_type history_key   [rqdf_pkg::HISTORY_DEPTH];
   bit                history_valid [rqdf_pkg::HISTORY_DEPTH];
   int                write_slot;

   query_item_type    pending_queries[$];
   logic              seen_expect[$];
   rqdf_pkg::key_type recorded_pool[$];

   int mismatches        = 0;
   int responses_checked = 0;
   int idle_cycles       = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // compare against all valid entries, then append on record
   function automatic logic lookup_and_record(input rqdf_pkg::key_type key, input logic action);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < rqdf_pkg::HISTORY_DEPTH; i++)
         if (history_valid[i] && history_key[i] == key)
            hit = 1'b1;
      if (action == ACT_RECORD) begin
         history_key[write_slot]   = key;
         history_valid[write_slot] = 1'b1;
         write_slot = (write_slot + 1) % rqdf_pkg::HISTORY_DEPTH;
      end
      return hit;
   endfunction

   function automatic void enqueue_query(input logic action, input rqdf_pkg::key_type key);
      query_item_type q;
      q.action = action;
      q.key    = key;
      pending_queries.insert(pending_queries.size(), q);
      if (action == ACT_RECORD) begin
         recorded_pool.insert(recorded_pool.size(), key);
         if (recorded_pool.size() > POOL_DEPTH)
            recorded_pool.delete(0);
      end
   endfunction

   // ---------------------------------------------------------------- driver
   logic        req_taken = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   bit          offer;

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            pending_queries.delete(0);
            if (burst_left > 0)
               burst_left--;
         end
         // a request still waiting for ready must stay put
         if (!(req_ch.valid && !req_taken)) begin
            if (burst_left == 0) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end
            end
            offer = (burst_left > 0) && (pending_queries.size() > 0);
            req_ch.valid <= offer;
            if (offer) begin
               req_ch.action      <= pending_queries[0].action;
               req_ch.query_id    <= pending_queries[0].key[63:48];
               req_ch.origin_ipv4 <= pending_queries[0].key[47:16];
               req_ch.origin_port <= pending_queries[0].key[15:0];
            end
         end
      end
   end

   // -------------------------------------------------------------- receiver
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned mode_left = 0;
   int unsigned rsp_mode  = 0;
   int unsigned pat_phase = 0;

   always @(negedge clock) begin
      pat_phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && responses_checked >= HOLD_AT) begin
         // long hold-off: sender keeps offering, block backs up
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rsp_mode  = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (rsp_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= (pat_phase % 5) >= 3;
         endcase
      end
   end

   // -------------------------------------------------- predictor and monitor
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready)
         seen_expect.insert(seen_expect.size(), lookup_and_record(
            {req_ch.query_id, req_ch.origin_ipv4, req_ch.origin_port}, req_ch.action));
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (seen_expect.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else if (rsp_ch.seen !== seen_expect[0]) begin
            report_mismatch($sformatf("response %0d: seen %b, expected %b",
                                      responses_checked, rsp_ch.seen, seen_expect[0]));
            seen_expect.delete(0);
         end else begin
            seen_expect.delete(0);
         end
         responses_checked++;
      end
   end

   // -------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------- stimulus and end
   initial begin
      rqdf_pkg::key_type ones;
      rqdf_pkg::key_type k;
      int                r;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_CHECK;
      req_ch.query_id    = '0;
      req_ch.origin_ipv4 = '0;
      req_ch.origin_port = '0;
      rsp_ch.ready       = 1'b0;
      write_slot         = 0;
      for (int i = 0; i < rqdf_pkg::HISTORY_DEPTH; i++) begin
         history_valid[i] = 1'b0;
         history_key[i]   = '0;
      end

      // directed: empty history, extremes, duplicate record, one-bit misses
      ones = '1;
      enqueue_query(ACT_CHECK,  '0);
      enqueue_query(ACT_RECORD, '0);
      enqueue_query(ACT_CHECK,  '0);
      enqueue_query(ACT_CHECK,  ones);
      enqueue_query(ACT_RECORD, ones);
      enqueue_query(ACT_RECORD, ones);
      enqueue_query(ACT_CHECK,  ones ^ (64'h1 << 48));
      enqueue_query(ACT_CHECK,  ones ^ (64'h1 << 16));
      enqueue_query(ACT_CHECK,  ones ^ 64'h1);
      // fill the history and wrap once, evicting the zero key
      for (int i = 1; i <= 14; i++)
         enqueue_query(ACT_RECORD, {16'(i), 32'hC0A8_0000 + 32'(i), 16'd6346});
      enqueue_query(ACT_CHECK, '0);
      enqueue_query(ACT_CHECK, ones);

      // random: recently recorded keys most often, some near misses, rest noise
      for (int n = 0; n < RANDOM_QUERIES; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45 && recorded_pool.size() > 0)
            k = recorded_pool[$urandom_range(0, recorded_pool.size() - 1)];
         else if (r < 60 && recorded_pool.size() > 0)
            k = recorded_pool[$urandom_range(0, recorded_pool.size() - 1)]
                ^ (64'h1 << $urandom_range(0, rqdf_pkg::KEY_W - 1));
         else
            k = {$urandom, $urandom};
         enqueue_query(($urandom_range(0, 99) < 55) ? ACT_RECORD : ACT_CHECK, k);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_queries.size() > 0 || seen_expect.size() > 0)
         @(posedge clock);
      repeat (rqdf_pkg::HISTORY_DEPTH + 8) @(posedge clock);

      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rqdf_pkg.sv
rtl/rqdf_if.sv
rtl/recent_query_duplicate_filter_top.sv
verif/tb_top.sv
